// ===== rtl/bbsf_pkg.sv =====
// shared types and constants for the bounded byte stream fifo
package bbsf_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int CMD_W     = 3;
  localparam int DATA_W    = 8;
  localparam int CAP_W     = 11;
  localparam int TOTAL_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_POP   = 3'd3,
    CMD_END   = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the beat and read the head entry
    logic commit;   // apply the command and load the result register
  } ctrl_cmd_t;

endpackage

// ===== rtl/bounded_byte_stream_fifo.sv =====
// top level of the bounded byte stream fifo
// a beat and the head entry, read with a registered port in the accept
//   cycle, are latched; the beat is applied once the result register is
//   free, and no new beat is taken before the last one is applied
// the result register lets the next beat in while a result waits
// reset: synchronous active low, clears pointers, counts, flags, totals;
//   capacity returns to 1024, the byte store is left as it is
module bounded_byte_stream_fifo
  import bbsf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: capacity register
  input  logic               cfg_wr_en,
  input  logic [CAP_W-1:0]   cfg_wr_data,
  // command beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [DATA_W-1:0]  in_data_byte,
  input  logic [CAP_W-1:0]   in_pop_count,
  // result beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic [DATA_W-1:0]  out_read_data,
  output logic [CAP_W-1:0]   out_stored_count,
  output logic [CAP_W-1:0]   out_free_space,
  output logic               out_end_marked,
  output logic               out_end_of_stream,
  output logic [TOTAL_W-1:0] out_total_written,
  output logic [TOTAL_W-1:0] out_total_read
);

  // capture and commit strobes from the sequencer
  ctrl_cmd_t cmd;

  // sequencer: idle until a beat arrives, then commit once the
  // result register is free
  bbsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // byte store, pointers, fill count, totals and the result register
  bbsf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_command        (in_command),
    .in_data_byte      (in_data_byte),
    .in_pop_count      (in_pop_count),
    .out_ok            (out_ok),
    .out_read_data     (out_read_data),
    .out_stored_count  (out_stored_count),
    .out_free_space    (out_free_space),
    .out_end_marked    (out_end_marked),
    .out_end_of_stream (out_end_of_stream),
    .out_total_written (out_total_written),
    .out_total_read    (out_total_read)
  );

endmodule

// ===== rtl/bbsf_ctrl.sv =====
// controller for the bounded byte stream fifo: sequencing and handshakes
module bbsf_ctrl
  import bbsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // wait here while the result register is still occupied
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/bbsf_datapath.sv =====
// datapath for the bounded byte stream fifo: byte store, pointers, counters
module bbsf_datapath
  import bbsf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  input  logic               cfg_wr_en,
  input  logic [CAP_W-1:0]   cfg_wr_data,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [DATA_W-1:0]  in_data_byte,
  input  logic [CAP_W-1:0]   in_pop_count,
  output logic               out_ok,
  output logic [DATA_W-1:0]  out_read_data,
  output logic [CAP_W-1:0]   out_stored_count,
  output logic [CAP_W-1:0]   out_free_space,
  output logic               out_end_marked,
  output logic               out_end_of_stream,
  output logic [TOTAL_W-1:0] out_total_written,
  output logic [TOTAL_W-1:0] out_total_read
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]   capacity_r;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CAP_W-1:0]   held_r, held_nxt;
  logic               ended_r, ended_nxt;
  logic [TOTAL_W-1:0] wr_total_r, wr_total_nxt;
  logic [TOTAL_W-1:0] rd_total_r, rd_total_nxt;

  logic [CMD_W-1:0]   cmd_r;
  logic [DATA_W-1:0]  data_r;
  logic [CAP_W-1:0]   pop_r;
  logic [DATA_W-1:0]  mem_q_r;

  logic [CAP_W-1:0]   eff_cap;
  logic [CAP_W-1:0]   adv_n;
  logic [SUM_W-1:0]   head_sum;
  logic [PTR_W-1:0]   head_adv;
  logic [PTR_W-1:0]   tail_adv;
  logic               wr_ok;
  logic               ok;
  logic [DATA_W-1:0]  rdata;

  // a capacity above the store size acts as the store size
  assign eff_cap = (32'(capacity_r) > DEPTH) ? CAP_W'(DEPTH) : capacity_r;

  // advance never exceeds held bytes, so the sum stays below twice the depth
  assign head_sum = SUM_W'(head_r) + SUM_W'(adv_n);
  assign head_adv = (32'(head_sum) >= DEPTH) ? PTR_W'(head_sum - SUM_W'(DEPTH))
                                             : PTR_W'(head_sum);
  assign tail_adv = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);

  assign wr_ok = (held_r < eff_cap);

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    held_nxt     = held_r;
    ended_nxt    = ended_r;
    wr_total_nxt = wr_total_r;
    rd_total_nxt = rd_total_r;
    adv_n        = '0;
    ok           = 1'b0;
    rdata        = '0;
    case (cmd_r) inside
      CMD_WRITE: begin
        if (wr_ok) begin
          tail_nxt     = tail_adv;
          held_nxt     = held_r + CAP_W'(1);
          wr_total_nxt = wr_total_r + TOTAL_W'(1);
          ok           = 1'b1;
        end
      end
      CMD_READ, CMD_PEEK: begin
        if (held_r != '0) begin
          rdata = mem_q_r;
          ok    = 1'b1;
          if (cmd_r == CMD_READ) begin
            adv_n        = CAP_W'(1);
            head_nxt     = head_adv;
            held_nxt     = held_r - CAP_W'(1);
            rd_total_nxt = rd_total_r + TOTAL_W'(1);
          end
        end
      end
      CMD_POP: begin
        adv_n        = (pop_r > held_r) ? held_r : pop_r;
        head_nxt     = head_adv;
        held_nxt     = held_r - adv_n;
        rd_total_nxt = rd_total_r + TOTAL_W'(adv_n);
        ok           = 1'b1;
      end
      CMD_END: begin
        ended_nxt = 1'b1;
        ok        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      head_r     <= '0;
      tail_r     <= '0;
      held_r     <= '0;
      ended_r    <= 1'b0;
      wr_total_r <= '0;
      rd_total_r <= '0;
    end else begin
      if (cfg_wr_en) capacity_r <= cfg_wr_data;
      if (cmd.commit) begin
        head_r     <= head_nxt;
        tail_r     <= tail_nxt;
        held_r     <= held_nxt;
        ended_r    <= ended_nxt;
        wr_total_r <= wr_total_nxt;
        rd_total_r <= rd_total_nxt;
      end
    end
  end

  // beat capture and byte store
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_command;
      data_r  <= in_data_byte;
      pop_r   <= in_pop_count;
      mem_q_r <= mem[head_r];
    end
    if (cmd.commit && (cmd_r == CMD_WRITE) && wr_ok) begin
      mem[tail_r] <= data_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ok            <= ok;
      out_read_data     <= rdata;
      out_stored_count  <= held_nxt;
      out_free_space    <= (eff_cap > held_nxt) ? eff_cap - held_nxt : '0;
      out_end_marked    <= ended_nxt;
      out_end_of_stream <= ended_nxt && (held_nxt == '0);
      out_total_written <= wr_total_nxt;
      out_total_read    <= rd_total_nxt;
    end
  end

endmodule
